// ----- sv/pfc_pkg.sv -----
// Shared constants and types for the pixel format converter.
package pfc_pkg;

  // Pixel word width and per-channel field sizes.
  localparam int PIXEL_BITS  = 32;
  localparam int CH_W_BITS   = 4;
  localparam int CH_POS_BITS = 5;
  localparam int NUM_CH      = 4;

  typedef logic [PIXEL_BITS-1:0] pixel_t;

  // Register indexes on the configuration port, taken from the word address.
  typedef enum logic [2:0] {
    REG_DEPTH      = 3'd0,
    REG_SRC_WIDTHS = 3'd1,
    REG_SRC_SHIFTS = 3'd2,
    REG_DST_WIDTHS = 3'd3,
    REG_DST_SHIFTS = 3'd4,
    REG_KEY_EN     = 3'd5,
    REG_KEY_VALUE  = 3'd6,
    REG_KEY_THRESH = 3'd7
  } reg_idx_t;

  // Depth codes: 8, 16, 24 or 32 bits per pixel.
  localparam logic [1:0] DEPTH_8  = 2'd0;
  localparam logic [1:0] DEPTH_16 = 2'd1;
  localparam logic [1:0] DEPTH_24 = 2'd2;
  localparam logic [1:0] DEPTH_32 = 2'd3;

endpackage

// ----- sv/pfc_in_if.sv -----
// Source pixel channel: valid/ready handshake with pixel and row-end payload.
interface pfc_in_if
  import pfc_pkg::*;
();
  logic   valid;
  logic   ready;
  pixel_t pixel_in;
  logic   row_end;

  modport source (output valid, output pixel_in, output row_end, input ready);
  modport sink   (input valid, input pixel_in, input row_end, output ready);
endinterface

// ----- sv/pfc_out_if.sv -----
// Result pixel channel: valid/ready handshake with pixel and row-end payload.
interface pfc_out_if
  import pfc_pkg::*;
();
  logic   valid;
  logic   ready;
  pixel_t pixel_out;
  logic   row_end_out;

  modport source (output valid, output pixel_out, output row_end_out, input ready);
  modport sink   (input valid, input pixel_out, input row_end_out, output ready);
endinterface

// ----- sv/pixel_format_converter.sv -----
// An accepted word passes through the input register and then the output register.
// Throughput: one word per cycle when not stalled; an input and an output register each hold one.
// The input register refills while a result waits if it is empty, so a stall leaves no bubble.
// Reset: synchronous, active low; clears the valid flags and loads the register defaults.
// Pixel format converter top level with register file and two-stage datapath.
module pixel_format_converter
  import pfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  pfc_in_if.sink      in_chan,
  pfc_out_if.source   out_chan,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [3:0]  depth_codes_r;
  logic [15:0] src_widths_r;
  logic [19:0] src_shifts_r;
  logic [15:0] dst_widths_r;
  logic [19:0] dst_shifts_r;
  logic        key_enable_r;
  pixel_t      key_value_r;
  logic [7:0]  key_thresh_r;

  reg_idx_t    reg_idx;
  logic        cfg_wr;

  logic        s1_valid_r;
  pixel_t      s1_pixel_r;
  logic        s1_row_end_r;
  logic        out_valid_r;
  pixel_t      out_pixel_r;
  logic        out_row_end_r;
  pixel_t      out_pixel_nxt;

  logic        out_free;
  logic        s1_free;

  // Mask for a depth code: 8, 16, 24 or 32 bits.
  function automatic pixel_t depth_mask(input logic [1:0] code);
    pixel_t m;
    begin
      case (code)
        DEPTH_8:  m = 32'h0000_00FF;
        DEPTH_16: m = 32'h0000_FFFF;
        DEPTH_24: m = 32'h00FF_FFFF;
        default:  m = 32'hFFFF_FFFF;
      endcase
      return m;
    end
  endfunction

  // Field extraction by bit position and width; width zero reads as zero.
  function automatic pixel_t field_get(input pixel_t px, input logic [CH_POS_BITS-1:0] pos,
                                       input logic [CH_W_BITS-1:0] w);
    pixel_t m;
    begin
      m = ~({PIXEL_BITS{1'b1}} << w);
      return (px >> pos) & m;
    end
  endfunction

  // Width rescaling: right shift to narrow, shift plus replicated low bits to widen.
  function automatic pixel_t rescale(input pixel_t c, input logic [CH_W_BITS-1:0] s,
                                     input logic [CH_W_BITS-1:0] d);
    logic [CH_W_BITS-1:0] k;
    logic [CH_W_BITS:0]   two_s;
    pixel_t               hi;
    pixel_t               r;
    begin
      k     = d - s;
      two_s = {s, 1'b0};
      hi    = c << k;
      if (s > d) begin
        r = c >> (s - d);
      end else if (two_s >= {1'b0, d}) begin
        r = hi | (c >> (two_s - {1'b0, d}));
      end else begin
        // c * (2^k - 1) written as a subtract; no wrap for widths up to 15.
        r = hi | (hi - c);
      end
      return r;
    end
  endfunction

  // One channel: extract, rescale and place at the destination position.
  function automatic pixel_t convert_channel(input pixel_t px, input int ch,
                                             input logic [15:0] sw_all,
                                             input logic [19:0] sp_all,
                                             input logic [15:0] dw_all,
                                             input logic [19:0] dp_all);
    logic [CH_W_BITS-1:0]   sw;
    logic [CH_W_BITS-1:0]   dw;
    logic [CH_POS_BITS-1:0] sp;
    logic [CH_POS_BITS-1:0] dp;
    begin
      sw = sw_all[ch*CH_W_BITS +: CH_W_BITS];
      dw = dw_all[ch*CH_W_BITS +: CH_W_BITS];
      sp = sp_all[ch*CH_POS_BITS +: CH_POS_BITS];
      dp = dp_all[ch*CH_POS_BITS +: CH_POS_BITS];
      return rescale(field_get(px, sp, sw), sw, dw) << dp;
    end
  endfunction

  // Register file write and read.
  assign reg_idx    = reg_idx_t'(cfg_paddr[4:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_codes_r <= 4'hF;
      src_widths_r  <= 16'h8888;
      src_shifts_r  <= 20'hC0110;
      dst_widths_r  <= 16'h8888;
      dst_shifts_r  <= 20'hC0110;
      key_enable_r  <= 1'b0;
      key_value_r   <= '0;
      key_thresh_r  <= 8'd1;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_DEPTH:      depth_codes_r <= cfg_pwdata[3:0];
        REG_SRC_WIDTHS: src_widths_r  <= cfg_pwdata[15:0];
        REG_SRC_SHIFTS: src_shifts_r  <= cfg_pwdata[19:0];
        REG_DST_WIDTHS: dst_widths_r  <= cfg_pwdata[15:0];
        REG_DST_SHIFTS: dst_shifts_r  <= cfg_pwdata[19:0];
        REG_KEY_EN:     key_enable_r  <= cfg_pwdata[0];
        REG_KEY_VALUE:  key_value_r   <= cfg_pwdata;
        REG_KEY_THRESH: key_thresh_r  <= cfg_pwdata[7:0];
        default:        key_thresh_r  <= key_thresh_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_DEPTH:      cfg_prdata = {28'd0, depth_codes_r};
      REG_SRC_WIDTHS: cfg_prdata = {16'd0, src_widths_r};
      REG_SRC_SHIFTS: cfg_prdata = {12'd0, src_shifts_r};
      REG_DST_WIDTHS: cfg_prdata = {16'd0, dst_widths_r};
      REG_DST_SHIFTS: cfg_prdata = {12'd0, dst_shifts_r};
      REG_KEY_EN:     cfg_prdata = {31'd0, key_enable_r};
      REG_KEY_VALUE:  cfg_prdata = key_value_r;
      REG_KEY_THRESH: cfg_prdata = {24'd0, key_thresh_r};
      default:        cfg_prdata = '0;
    endcase
  end

  // Stage flow control: each register loads when it is empty or being drained.
  assign out_free      = !out_valid_r || out_chan.ready;
  assign s1_free       = !s1_valid_r || out_free;
  assign in_chan.ready = s1_free;

  // Input register: source pixel cut to its depth.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_free) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && in_chan.valid) begin
      s1_pixel_r   <= in_chan.pixel_in & depth_mask(depth_codes_r[1:0]);
      s1_row_end_r <= in_chan.row_end;
    end
  end

  // Conversion: color channels, then alpha conversion or color keying.
  always_comb begin
    logic [CH_W_BITS-1:0] sa;
    pixel_t               alpha;
    pixel_t               res;
    sa    = src_widths_r[3*CH_W_BITS +: CH_W_BITS];
    alpha = field_get(s1_pixel_r, src_shifts_r[3*CH_POS_BITS +: CH_POS_BITS], sa);
    res   = convert_channel(s1_pixel_r, 0, src_widths_r, src_shifts_r,
                            dst_widths_r, dst_shifts_r)
          | convert_channel(s1_pixel_r, 1, src_widths_r, src_shifts_r,
                            dst_widths_r, dst_shifts_r)
          | convert_channel(s1_pixel_r, 2, src_widths_r, src_shifts_r,
                            dst_widths_r, dst_shifts_r);
    if (sa != '0) begin
      if (key_enable_r) begin
        if (alpha < {24'd0, key_thresh_r}) begin
          res = key_value_r;
        end
      end else begin
        res = res | convert_channel(s1_pixel_r, 3, src_widths_r, src_shifts_r,
                                    dst_widths_r, dst_shifts_r);
      end
    end
    out_pixel_nxt = res & depth_mask(depth_codes_r[3:2]);
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid_r) begin
      out_pixel_r   <= out_pixel_nxt;
      out_row_end_r <= s1_row_end_r;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.pixel_out   = out_pixel_r;
  assign out_chan.row_end_out = out_row_end_r;

endmodule
